>>> rtl/cbtb_pkg.sv
// shared types and constants for the bit test and branch unit
package cbtb_pkg;

   // byte memory geometry
   localparam int MEM_ADDR_BITS = 16;
   localparam int MEM_DEPTH     = 1 << MEM_ADDR_BITS;

   typedef logic [MEM_ADDR_BITS-1:0] mem_addr_type;

   // instruction classes
   typedef enum logic [4:0] {
      KIND_BRA      = 5'd0,
      KIND_BIT_IMM  = 5'd1,
      KIND_BIT_ZPX  = 5'd2,
      KIND_BIT_ABSX = 5'd3,
      KIND_TRB_ZP   = 5'd4,
      KIND_TRB_ABS  = 5'd5,
      KIND_TSB_ZP   = 5'd6,
      KIND_TSB_ABS  = 5'd7,
      KIND_RMB      = 5'd8,
      KIND_SMB      = 5'd9,
      KIND_BBR      = 5'd10,
      KIND_BBS      = 5'd11,
      KIND_STZ_ABS  = 5'd12,
      KIND_STZ_ABSX = 5'd13,
      KIND_STZ_ZP   = 5'd14,
      KIND_STZ_ZPX  = 5'd15,
      KIND_BRL      = 5'd16,
      KIND_JMP_INDX = 5'd17,
      KIND_HOST_WR  = 5'd18,
      KIND_HOST_RD  = 5'd19
   } kind_type;

   // flag write mask codes
   localparam logic [1:0] FW_NONE = 2'd0;
   localparam logic [1:0] FW_Z    = 2'd1;
   localparam logic [1:0] FW_ZNV  = 2'd2;

   // input beat
   typedef struct packed {
      logic [4:0]  kind;
      logic [2:0]  bit_number;
      logic [15:0] operand;
      logic [7:0]  accumulator;
      logic [7:0]  index_x;
      logic [15:0] pc_in;
      logic [7:0]  host_data;
   } req_type;

   // result beat
   typedef struct packed {
      logic [15:0] new_pc;
      logic        flag_zero;
      logic        flag_negative;
      logic        flag_overflow;
      logic [1:0]  flags_written;
      logic [2:0]  cycles_added;
      logic [7:0]  read_data;
   } rsp_type;

endpackage

>>> rtl/cbtb_ram.sv
// generic ram: one write port, two registered read ports, read-first
module cbtb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_a,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_a_ff;
   logic [WIDTH-1:0] rd_data_b_ff;

   // storage write
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered reads, old data on a same-edge write
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_a_ff <= mem_ff[rd_addr_a];
         rd_data_b_ff <= mem_ff[rd_addr_b];
      end
   end

   assign rd_data_a = rd_data_a_ff;
   assign rd_data_b = rd_data_b_ff;

endmodule

>>> rtl/cpu_bit_test_and_branch_unit.sv
// top level of the bit test and branch unit: address, memory access, execute
//
// Usage:
//   req channel (req_valid/req_ready/req_data) takes one instruction beat:
//   class, bit number, operand, A, X, program counter and host byte.
//   rsp channel (rsp_valid/rsp_ready/rsp_data) returns one beat per request:
//   new program counter, Z/N/V with their write mask, cycle increment and
//   the byte of a host read.
//   One beat per cycle is sustained while rsp_ready is high. The addresses
//   are formed on acceptance and both memory read ports fire on the same
//   edge; the execute stage then modifies the data, writes it back through
//   the single write port and registers the result for output.
//   A write that lands on the edge at which the next beat reads the same
//   byte is forwarded, so back to back read-modify-writes see fresh data.
//   The pointer of an indexed indirect jump uses both read ports, high byte on the second.
//   Reset empties the pipeline and the output register; memory contents are
//   not cleared and a byte must be written before it is read.
//   When rsp_ready stays low the output register holds its beat, the execute
//   stage holds one more, and req_ready drops until space frees up.
module cpu_bit_test_and_branch_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  cbtb_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output cbtb_pkg::rsp_type rsp_data
);

   import cbtb_pkg::*;

   // address stage
   logic [7:0]   zp8;
   logic [7:0]   zpx8;
   logic [7:0]   zpx1_8;
   logic [15:0]  absx16;
   logic [15:0]  addr_a16;
   logic [15:0]  addr_b16;
   logic         req_fire;

   // execute stage
   logic         s1_valid_ff;
   req_type      s1_req_ff;
   mem_addr_type s1_addr_a_ff;
   mem_addr_type s1_addr_b_ff;
   logic         s1_adv;

   // last write, for forwarding
   logic         fwd_valid_ff;
   mem_addr_type fwd_addr_ff;
   logic [7:0]   fwd_data_ff;

   // memory ports
   logic         mem_wr_en;
   logic [7:0]   mem_wr_data;
   logic [7:0]   ram_rd_a;
   logic [7:0]   ram_rd_b;
   logic [7:0]   val_a;
   logic [7:0]   val_b;

   // execute results
   rsp_type      exe_rsp;
   logic         exe_write;

   // output register
   logic         rsp_valid_ff;
   rsp_type      rsp_data_ff;

   // handshake
   assign s1_adv    = !rsp_valid_ff || rsp_ready;
   assign req_ready = !s1_valid_ff || s1_adv;
   assign req_fire  = req_valid && req_ready;

   // address generation, zero page wraps at 8 bits, indexed at 16
   always_comb begin
      zp8      = req_data.operand[7:0];
      zpx8     = 8'(req_data.operand[7:0] + req_data.index_x);
      zpx1_8   = 8'(req_data.operand[7:0] + req_data.index_x + 8'd1);
      absx16   = 16'(req_data.operand + {8'h00, req_data.index_x});
      addr_b16 = {8'h00, zpx1_8};
      unique case (req_data.kind)
         KIND_BIT_ZPX, KIND_STZ_ZPX, KIND_JMP_INDX: addr_a16 = {8'h00, zpx8};
         KIND_BIT_ABSX, KIND_STZ_ABSX:              addr_a16 = absx16;
         KIND_TRB_ZP, KIND_TSB_ZP, KIND_RMB, KIND_SMB,
         KIND_BBR, KIND_BBS, KIND_STZ_ZP:           addr_a16 = {8'h00, zp8};
         default:                                   addr_a16 = req_data.operand;
      endcase
   end

   // byte memory
   cbtb_ram #(
      .WIDTH (8),
      .DEPTH (MEM_DEPTH)
   ) u_mem (
      .clock     (clock),
      .wr_en     (mem_wr_en),
      .wr_addr   (s1_addr_a_ff),
      .wr_data   (mem_wr_data),
      .rd_en     (req_fire),
      .rd_addr_a (addr_a16[MEM_ADDR_BITS-1:0]),
      .rd_addr_b (addr_b16[MEM_ADDR_BITS-1:0]),
      .rd_data_a (ram_rd_a),
      .rd_data_b (ram_rd_b)
   );

   // execute stage control
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ready) begin
         s1_valid_ff <= req_valid;
      end
   end

   // execute stage payload
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_req_ff    <= req_data;
         s1_addr_a_ff <= addr_a16[MEM_ADDR_BITS-1:0];
         s1_addr_b_ff <= addr_b16[MEM_ADDR_BITS-1:0];
      end
   end

   // forward the last write over stale read data
   assign val_a = (fwd_valid_ff && fwd_addr_ff == s1_addr_a_ff) ? fwd_data_ff : ram_rd_a;
   assign val_b = (fwd_valid_ff && fwd_addr_ff == s1_addr_b_ff) ? fwd_data_ff : ram_rd_b;

   // execute: flags, write back value, next program counter
   always_comb begin
      logic [7:0]  bit_mask;
      logic [15:0] pc;
      logic [15:0] rel8;
      logic [15:0] rel_bb;
      logic        bit_set;
      bit_mask  = 8'h01 << s1_req_ff.bit_number;
      pc        = s1_req_ff.pc_in;
      rel8      = {{8{s1_req_ff.operand[7]}}, s1_req_ff.operand[7:0]};
      rel_bb    = {{8{s1_req_ff.operand[15]}}, s1_req_ff.operand[15:8]};
      bit_set   = (val_a & bit_mask) != 8'h00;
      exe_rsp   = '0;
      exe_rsp.new_pc = pc;
      exe_write   = 1'b0;
      mem_wr_data = 8'h00;
      unique case (s1_req_ff.kind)
         KIND_BRA: begin
            exe_rsp.new_pc = 16'(pc + 16'd2 + rel8);
         end
         KIND_BIT_IMM: begin
            exe_rsp.flag_zero     = (s1_req_ff.accumulator & s1_req_ff.operand[7:0]) == 8'h00;
            exe_rsp.flags_written = FW_Z;
            exe_rsp.cycles_added  = 3'd2;
            exe_rsp.new_pc        = 16'(pc + 16'd2);
         end
         KIND_BIT_ZPX, KIND_BIT_ABSX: begin
            exe_rsp.flag_zero     = (s1_req_ff.accumulator & val_a) == 8'h00;
            exe_rsp.flag_negative = val_a[7];
            exe_rsp.flag_overflow = val_a[6];
            exe_rsp.flags_written = FW_ZNV;
            exe_rsp.cycles_added  = 3'd4;
            exe_rsp.new_pc        = (s1_req_ff.kind == KIND_BIT_ZPX) ?
                                    16'(pc + 16'd2) : 16'(pc + 16'd3);
         end
         KIND_TRB_ZP, KIND_TRB_ABS, KIND_TSB_ZP, KIND_TSB_ABS: begin
            exe_rsp.flag_zero     = (s1_req_ff.accumulator & val_a) == 8'h00;
            exe_rsp.flags_written = FW_Z;
            exe_write             = 1'b1;
            mem_wr_data = (s1_req_ff.kind == KIND_TRB_ZP || s1_req_ff.kind == KIND_TRB_ABS) ?
                          (val_a & ~s1_req_ff.accumulator) : (val_a | s1_req_ff.accumulator);
            if (s1_req_ff.kind[0]) begin
               exe_rsp.cycles_added = 3'd6;
               exe_rsp.new_pc       = 16'(pc + 16'd3);
            end else begin
               exe_rsp.cycles_added = 3'd5;
               exe_rsp.new_pc       = 16'(pc + 16'd2);
            end
         end
         KIND_RMB, KIND_SMB: begin
            exe_write   = 1'b1;
            mem_wr_data = (s1_req_ff.kind == KIND_RMB) ? (val_a & ~bit_mask) : (val_a | bit_mask);
            exe_rsp.cycles_added = 3'd5;
            exe_rsp.new_pc       = 16'(pc + 16'd2);
         end
         KIND_BBR, KIND_BBS: begin
            if ((s1_req_ff.kind == KIND_BBS) == bit_set) begin
               exe_rsp.new_pc = 16'(pc + 16'd3 + rel_bb);
            end else begin
               exe_rsp.new_pc = 16'(pc + 16'd3);
            end
         end
         KIND_STZ_ABS: begin
            exe_write = 1'b1;
            exe_rsp.cycles_added = 3'd4;
            exe_rsp.new_pc       = 16'(pc + 16'd3);
         end
         KIND_STZ_ABSX: begin
            exe_write = 1'b1;
            exe_rsp.cycles_added = 3'd5;
            exe_rsp.new_pc       = 16'(pc + 16'd3);
         end
         KIND_STZ_ZP: begin
            exe_write = 1'b1;
            exe_rsp.cycles_added = 3'd3;
            exe_rsp.new_pc       = 16'(pc + 16'd2);
         end
         KIND_STZ_ZPX: begin
            exe_write = 1'b1;
            exe_rsp.cycles_added = 3'd4;
            exe_rsp.new_pc       = 16'(pc + 16'd2);
         end
         KIND_BRL: begin
            exe_rsp.new_pc = 16'(pc + 16'd3 + s1_req_ff.operand);
         end
         KIND_JMP_INDX: begin
            exe_rsp.new_pc = {val_b, val_a};
         end
         KIND_HOST_WR: begin
            exe_write   = 1'b1;
            mem_wr_data = s1_req_ff.host_data;
         end
         KIND_HOST_RD: begin
            exe_rsp.read_data = val_a;
         end
         default: begin
            exe_write = 1'b0;
         end
      endcase
   end

   assign mem_wr_en = s1_valid_ff && s1_adv && exe_write;

   // last write tracking
   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_valid_ff <= 1'b0;
      end else if (mem_wr_en) begin
         fwd_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_wr_en) begin
         fwd_addr_ff <= s1_addr_a_ff;
         fwd_data_ff <= mem_wr_data;
      end
   end

   // output register control
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_adv) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   // output register payload
   always_ff @(posedge clock) begin
      if (s1_adv && s1_valid_ff) begin
         rsp_data_ff <= exe_rsp;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // a beat is only taken when the execute stage is empty or can move on
   a_accept_room: assert property (@(posedge clock) disable iff (reset)
      req_fire |-> (!s1_valid_ff || s1_adv))
      else $error("request beat taken while execute stage blocked");

   // memory is written only by a beat leaving the execute stage
   a_write_on_move: assert property (@(posedge clock) disable iff (reset)
      mem_wr_en |-> (s1_valid_ff && s1_adv))
      else $error("memory write without execute stage advance");

   // a blocked execute stage keeps its beat
   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_adv) |=> (s1_valid_ff && $stable(s1_req_ff)))
      else $error("execute stage beat lost while blocked");

   // a beat leaving execute shows up at the output
   a_s1_to_rsp: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s1_adv) |=> rsp_valid_ff)
      else $error("execute beat did not reach output register");

   // reset empties the output, the execute stage and the forwarding register
   a_reset_empty: assert property (@(posedge clock)
      reset |=> (!rsp_valid_ff && !s1_valid_ff && !fwd_valid_ff))
      else $error("pipeline not empty after reset");

endmodule
